### rtl/pngf_pkg.sv
// Shared types and constants for the PNG scanline filter.
// Depends on nothing; imported by every module of the block.
package pngf_pkg;

   // Filter type codes as carried in the stream
   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;

   // Field and register widths
   localparam int PIX_W  = 13;   // row_pixels register
   localparam int BPP_W  = 3;    // bytes_per_pixel register
   localparam int PROD_W = 16;   // row_pixels * bytes_per_pixel
   localparam int SUM_W  = 17;   // column compare width, holds any row length

   // Decoupling queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPW    = 2;
   localparam int QCW    = 3;

   // One classified byte handed from front to back
   typedef struct packed {
      logic [7:0] sample;     // raw byte
      logic [7:0] upper;      // byte above, zero without a previous row
      logic [2:0] filt;       // latched row filter
      logic       first;      // first byte of a row, needs a type tag ahead
      logic       last;       // last byte of a row
      logic       bad;        // row filter above Paeth
      logic       left_ok;    // left neighbor lies inside the row
      logic       upleft_ok;  // up-left neighbor exists
   } entry_type;

endpackage

### rtl/pngf_front.sv
// Front end of the PNG scanline filter: accepts raw bytes, tracks the column,
// latches the row filter and reads the previous row from the line store.
// Depends on pngf_pkg.
module pngf_front #(
   parameter int MAX_ROW_BYTES = 16384
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_sample,
   input  logic [2:0]                    req_filter_type,
   input  logic                          req_image_start,
   input  logic                          room,
   input  logic [pngf_pkg::BPP_W-1:0]    bpp_eff,
   input  logic [pngf_pkg::PROD_W-1:0]   len_prod,
   output logic                          push_valid,
   output pngf_pkg::entry_type           push_entry
);
   import pngf_pkg::*;

   localparam int CW = $clog2(MAX_ROW_BYTES);

   logic [7:0]      line_mem [MAX_ROW_BYTES];
   logic [CW-1:0]   col_ff, col_in, col_eff;
   logic            have_ff, have_in, have_eff;
   logic [2:0]      filt_ff, filt_in, filt_eff;
   logic            s1_valid_ff, s1_have_ff;
   entry_type       s1_entry_ff, s1_entry_in;
   logic [7:0]      rd_ff;
   logic            accept, first, last;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   // Classify the incoming byte against the current row position
   always_comb begin
      col_eff  = req_image_start ? '0 : col_ff;
      have_eff = req_image_start ? 1'b0 : have_ff;
      first    = (col_eff == '0);
      filt_eff = first ? req_filter_type : filt_ff;
      last     = ((SUM_W'(col_eff) + SUM_W'(1)) >= SUM_W'(len_prod)) ||
                 (col_eff == CW'(MAX_ROW_BYTES - 1));

      s1_entry_in           = '0;
      s1_entry_in.sample    = req_sample;
      s1_entry_in.filt      = filt_eff;
      s1_entry_in.first     = first;
      s1_entry_in.last      = last;
      s1_entry_in.bad       = (filt_eff > FILT_PAETH);
      s1_entry_in.left_ok   = (SUM_W'(col_eff) >= SUM_W'(bpp_eff));
      s1_entry_in.upleft_ok = have_eff && (SUM_W'(col_eff) >= SUM_W'(bpp_eff));

      col_in  = col_ff;
      have_in = have_ff;
      filt_in = filt_ff;
      if (accept) begin
         col_in  = last ? '0 : col_eff + CW'(1);
         have_in = last ? 1'b1 : have_eff;
         filt_in = filt_eff;
      end
   end

   // Line store: read the byte above, then overwrite it with this row's byte
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff             <= line_mem[col_eff];
         line_mem[col_eff] <= req_sample;
      end
   end

   // Hold the classified byte while the store read completes
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_entry_ff <= s1_entry_in;
         s1_have_ff  <= have_eff;
      end
   end

   // Row position state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         have_ff     <= 1'b0;
         filt_ff     <= FILT_NONE;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         have_ff     <= have_in;
         filt_ff     <= filt_in;
         s1_valid_ff <= accept;
      end
   end

   // Merge the store read into the queued transaction
   always_comb begin
      push_valid       = s1_valid_ff;
      push_entry       = s1_entry_ff;
      push_entry.upper = s1_have_ff ? rd_ff : 8'd0;
   end

endmodule

### rtl/pngf_queue.sv
// Short FIFO between the front and back ends of the PNG scanline filter.
// Depends on pngf_pkg.
module pngf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pngf_pkg::entry_type        push_entry,
   input  logic                       pop,
   output logic                       head_valid,
   output pngf_pkg::entry_type        head,
   output logic [pngf_pkg::QCW-1:0]   count
);
   import pngf_pkg::*;

   entry_type        slot_ff [QDEPTH];
   logic [QPW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCW'(1);
         2'b01:   count_in = count_ff - QCW'(1);
         default: count_in = count_ff;
      endcase
   end

   // Store pushed transactions
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

### rtl/pngf_back.sv
// Back end of the PNG scanline filter: keeps the left and up-left history,
// applies the row filter and emits the type tag and filtered bytes.
// Depends on pngf_pkg.
module pngf_back #(
   parameter int MAX_PIXEL_BYTES = 4,
   parameter int PIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  pngf_pkg::entry_type   head,
   input  logic [PIW-1:0]        tap_idx,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_is_type_tag,
   output logic                  rsp_row_end,
   output logic                  rsp_bad_type
);
   import pngf_pkg::*;

   logic [7:0]  left_ff   [MAX_PIXEL_BYTES];
   logic [7:0]  upleft_ff [MAX_PIXEL_BYTES];
   logic        tag_sent_ff;
   logic        rsp_valid_ff;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        is_tag_ff, is_tag_in, row_end_ff, row_end_in, bad_ff;
   logic        load, send_tag;
   logic [7:0]  a, b, c, pred;
   logic [8:0]  ab_sum;

   // Paeth predictor: nearest of a, b, c to a + b - c, ties to a then b
   function automatic logic [7:0] paeth_pred(input logic [7:0] pa_a,
                                             input logic [7:0] pa_b,
                                             input logic [7:0] pa_c);
      logic signed [9:0] da, db, dc;
      logic        [9:0] pa, pb, pc;
      begin
         da = signed'(10'(pa_b)) - signed'(10'(pa_c));
         db = signed'(10'(pa_a)) - signed'(10'(pa_c));
         dc = da + db;
         pa = (da < 0) ? 10'(-da) : 10'(da);
         pb = (db < 0) ? 10'(-db) : 10'(db);
         pc = (dc < 0) ? 10'(-dc) : 10'(dc);
         if (pa <= pb && pa <= pc) begin
            paeth_pred = pa_a;
         end else if (pb <= pc) begin
            paeth_pred = pa_b;
         end else begin
            paeth_pred = pa_c;
         end
      end
   endfunction

   assign load     = !rsp_valid_ff || !rsp_stall;
   assign send_tag = head.first && !tag_sent_ff;
   assign pop      = load && head_valid && !send_tag;

   // Pick neighbors and form the prediction
   always_comb begin
      a      = head.left_ok ? left_ff[tap_idx] : 8'd0;
      b      = head.upper;
      c      = head.upleft_ok ? upleft_ff[tap_idx] : 8'd0;
      ab_sum = 9'(a) + 9'(b);
      case (head.filt)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = ab_sum[8:1];
         FILT_PAETH: pred = paeth_pred(a, b, c);
         default:    pred = 8'd0;
      endcase

      if (send_tag) begin
         out_byte_in = 8'(head.filt);
         is_tag_in   = 1'b1;
         row_end_in  = 1'b0;
      end else begin
         out_byte_in = head.sample - pred;
         is_tag_in   = 1'b0;
         row_end_in  = head.last;
      end
   end

   // Shift raw and up bytes into the history on each consumed byte
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
            left_ff[i]   <= left_ff[i-1];
            upleft_ff[i] <= upleft_ff[i-1];
         end
         left_ff[0]   <= head.sample;
         upleft_ff[0] <= head.upper;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         out_byte_ff <= out_byte_in;
         is_tag_ff   <= is_tag_in;
         row_end_ff  <= row_end_in;
         bad_ff      <= head.bad;
      end
   end

   // Output valid and tag sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tag_sent_ff  <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= head_valid;
         if (head_valid) begin
            tag_sent_ff <= send_tag;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_is_type_tag = is_tag_ff;
   assign rsp_row_end     = row_end_ff;
   assign rsp_bad_type    = bad_ff;

endmodule

### rtl/png_scanline_filter.sv
// PNG scanline filter: takes raw image bytes in row order and returns the
// filtered scanline (None, Sub, Up, Average, Paeth), with the row's filter
// type byte ahead of each row. Throughput, set by the single output register,
// is one byte or type byte per cycle unless rsp_stall holds the flow; each
// row's type byte takes an output slot of its own. A request passes through
// the line store read register, the queue and the output register. The line
// store holds MAX_ROW_BYTES bytes and needs no clearing after reset.
// Configuration registers: row_pixels at 0x0 and bytes_per_pixel at 0x4;
// write them only while no transaction is in flight.
// Depends on pngf_pkg, pngf_front, pngf_queue and pngf_back.
module png_scanline_filter #(
   parameter int MAX_ROW_BYTES   = 16384,
   parameter int MAX_PIXEL_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_sample,
   input  logic [2:0]   req_filter_type,
   input  logic         req_image_start,
   // response channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_is_type_tag,
   output logic         rsp_row_end,
   output logic         rsp_bad_type,
   // configuration port
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import pngf_pkg::*;

   localparam int PIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam logic REG_ROW_PIXELS      = 1'b0;
   localparam logic REG_BYTES_PER_PIXEL = 1'b1;

   logic [PIX_W-1:0]   row_pixels_ff;
   logic [BPP_W-1:0]   bpp_ff;
   logic [PIX_W-1:0]   pix_eff;
   logic [BPP_W-1:0]   bpp_eff;
   logic [PROD_W-1:0]  len_prod;
   logic [PIW-1:0]     tap_idx;
   logic               cfg_write, room, push_valid, pop, head_valid;
   entry_type          push_entry, head;
   logic [QCW-1:0]     q_count;

   // Register access
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pixels_ff <= PIX_W'(1);
         bpp_ff        <= BPP_W'(1);
      end else if (cfg_write) begin
         case (paddr[2])
            REG_ROW_PIXELS:      row_pixels_ff <= pwdata[PIX_W-1:0];
            REG_BYTES_PER_PIXEL: bpp_ff        <= pwdata[BPP_W-1:0];
            default:             row_pixels_ff <= row_pixels_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ROW_PIXELS:      prdata = 32'(row_pixels_ff);
         REG_BYTES_PER_PIXEL: prdata = 32'(bpp_ff);
         default:             prdata = 32'd0;
      endcase
   end

   // Effective pixel size and row length; zero acts as one, and the pixel size saturates at MAX_PIXEL_BYTES
   always_comb begin
      pix_eff = (row_pixels_ff == '0) ? PIX_W'(1) : row_pixels_ff;
      bpp_eff = (bpp_ff == '0) ? BPP_W'(1) : bpp_ff;
      if (4'(bpp_eff) > 4'(MAX_PIXEL_BYTES)) begin
         bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
      end
      len_prod = PROD_W'(pix_eff) * PROD_W'(bpp_eff);
      tap_idx  = PIW'(bpp_eff - BPP_W'(1));
   end

   // Accept only while the queue can absorb the byte in the read stage
   assign room = (QCW'(q_count) + QCW'(push_valid)) < QCW'(QDEPTH);

   pngf_front #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_filter_type (req_filter_type),
      .req_image_start (req_image_start),
      .room            (room),
      .bpp_eff         (bpp_eff),
      .len_prod        (len_prod),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   pngf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .count      (q_count)
   );

   pngf_back #(
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
      .PIW             (PIW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .tap_idx         (tap_idx),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_type_tag (rsp_is_type_tag),
      .rsp_row_end     (rsp_row_end),
      .rsp_bad_type    (rsp_bad_type)
   );

endmodule

### tb/sv/tb_top.sv
// Testbench for png_scanline_filter: predicts every filtered byte and type tag
// of the scanline stream and compares them with the block's results.
// Depends on pngf_pkg and png_scanline_filter.
module tb_top;
   import pngf_pkg::*;

   localparam int MAX_ROW_BYTES   = 16384;
   localparam int MAX_PIXEL_BYTES = 4;

   // register indexes on the configuration port
   localparam int REG_ROW_PIXELS      = 0;
   localparam int REG_BYTES_PER_PIXEL = 1;

   localparam logic [7:0] DIR_BYTES [16] = '{
      8'hFF, 8'h01, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'hFF, 8'h01,
      8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'hFF};
   localparam logic [2:0] DIR_TYPES [4] = '{FILT_PAETH, FILT_AVG, FILT_SUB, FILT_UP};

   localparam int PHASES = 10;
   localparam int PHASE_PIX [PHASES] = '{0, 1, 3, 4096, 2, 5, 7, 1, 16, 8191};
   localparam int PHASE_BPP [PHASES] = '{0, 4, 3, 1, 7, 2, 1, 1, 5, 2};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_type_tag;
      logic       row_end;
      logic       bad_type;
   } filt_result_type;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_type;

   // Scanline predictor: keeps the row above, the left and up-left bytes and the
   // row position, and queues the results each accepted byte must produce.
   class scanline_check;
      logic [7:0]      prev_row [MAX_ROW_BYTES];
      logic [7:0]      left_hist [MAX_PIXEL_BYTES];
      logic [7:0]      upleft_hist [MAX_PIXEL_BYTES];
      int              col;
      bit              have_prev;
      logic [2:0]      row_filt;
      logic [12:0]     row_pixels;
      logic [2:0]      pixel_bytes_reg;
      int              written_max;
      filt_result_type filtered_q [$];
      int              errors;

      function new();
         left_hist   = '{default: 8'h00};
         upleft_hist = '{default: 8'h00};
         col         = 0;
         have_prev   = 1'b0;
         row_filt    = FILT_NONE;
         row_pixels  = 13'd1;
         pixel_bytes_reg = 3'd1;
         written_max = -1;
         errors      = 0;
      endfunction

      function void set_reg(int idx, int val);
         if (idx == REG_ROW_PIXELS) row_pixels = val[12:0];
         else if (idx == REG_BYTES_PER_PIXEL) pixel_bytes_reg = val[2:0];
      endfunction

      // zero acts as one, anything above the history depth saturates
      function int pixel_bytes();
         int b;
         b = (pixel_bytes_reg == 0) ? 1 : pixel_bytes_reg;
         return (b > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : b;
      endfunction

      function int row_length();
         int p, l;
         p = (row_pixels == 0) ? 1 : row_pixels;
         l = p * pixel_bytes();
         return (l > MAX_ROW_BYTES) ? MAX_ROW_BYTES : l;
      endfunction

      // true when the byte would fetch a line store entry never written
      function bit reads_unwritten(logic img);
         return !img && have_prev && col > written_max;
      endfunction

      function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
         int p, pa, pb, pc;
         p  = int'(a) + int'(b) - int'(c);
         pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
         pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
         pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
         if (pa <= pb && pa <= pc) return a;
         if (pb <= pc) return b;
         return c;
      endfunction

      function void push_result(logic [7:0] v, logic tag, logic fin, logic bad);
         filt_result_type r;
         r.out_byte    = v;
         r.is_type_tag = tag;
         r.row_end     = fin;
         r.bad_type    = bad;
         filtered_q = {filtered_q, r};
      endfunction

      // predict the results of one accepted raw byte
      function void note_byte(logic [7:0] x, logic [2:0] ft, logic img);
         int         bpp, len, k;
         logic [7:0] a, b, c, pred;
         logic       bad, fin;
         bpp = pixel_bytes();
         len = row_length();
         if (img) begin
            col       = 0;
            have_prev = 1'b0;
         end
         if (col >= MAX_ROW_BYTES) col = MAX_ROW_BYTES - 1;
         // latch the row filter and clear the neighbors at row start
         if (col == 0) begin
            row_filt    = ft;
            left_hist   = '{default: 8'h00};
            upleft_hist = '{default: 8'h00};
         end
         bad = (row_filt > FILT_PAETH);
         if (col == 0) push_result({5'd0, row_filt}, 1'b1, 1'b0, bad);

         a = (col >= bpp) ? left_hist[bpp-1] : 8'h00;
         b = have_prev ? prev_row[col] : 8'h00;
         c = (have_prev && col >= bpp) ? upleft_hist[bpp-1] : 8'h00;
         case (row_filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'h00;
         endcase

         // shift histories and store the raw byte for the next row
         for (k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
            left_hist[k]   = left_hist[k-1];
            upleft_hist[k] = upleft_hist[k-1];
         end
         left_hist[0]   = x;
         upleft_hist[0] = b;
         prev_row[col]  = x;
         if (col > written_max) written_max = col;

         fin = (col + 1 >= len);
         push_result(x - pred, 1'b0, fin, bad);
         if (fin) begin
            col       = 0;
            have_prev = 1'b1;
         end else begin
            col++;
         end
      endfunction

      function void check_result(logic [7:0] v, logic tag, logic fin, logic bad);
         filt_result_type e;
         if (filtered_q.size() == 0) begin
            $error("unexpected result: out_byte %0h tag %0b row_end %0b bad_type %0b",
                   v, tag, fin, bad);
            errors++;
            return;
         end
         e = filtered_q.pop_front();
         if (v !== e.out_byte) begin
            $error("out_byte: expected %0h, got %0h", e.out_byte, v);
            errors++;
         end
         if (tag !== e.is_type_tag) begin
            $error("is_type_tag: expected %0b, got %0b", e.is_type_tag, tag);
            errors++;
         end
         if (fin !== e.row_end) begin
            $error("row_end: expected %0b, got %0b", e.row_end, fin);
            errors++;
         end
         if (bad !== e.bad_type) begin
            $error("bad_type: expected %0b, got %0b", e.bad_type, bad);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_sample = 8'h00;
   logic [2:0]  req_filter_type = FILT_NONE;
   logic        req_image_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_type_tag;
   logic        rsp_row_end;
   logic        rsp_bad_type;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   scanline_check sb = new();
   rx_mode_type   rx_mode = RX_OPEN;
   int            rx_left = 0;
   int            burst_left = 0;
   bit            gaps_on = 1'b1;

   png_scanline_filter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_filter_type (req_filter_type),
      .req_image_start (req_image_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_type_tag (rsp_is_type_tag),
      .rsp_row_end     (rsp_row_end),
      .rsp_bad_type    (rsp_bad_type),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: switch between open, light, heavy and bursty stall patterns
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(20, 300);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN:  rsp_stall <= 1'b0;
         RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:  rsp_stall <= ($urandom_range(0, 15) == 0) ? ~rsp_stall : rsp_stall;
      endcase
   end

   // check each result transaction, sampled mid cycle ahead of its accepting edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_byte, rsp_is_type_tag, rsp_row_end, rsp_bad_type);
   end

   // present one byte, idling between bursts; return at the accepting edge
   task automatic send_byte(input logic [7:0] s, input logic [2:0] ft, input logic img);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_filter_type <= ft;
      req_image_start <= img;
      do @(negedge clock); while (req_stall);
      sb.note_byte(s, ft, img);
      @(posedge clock);
   endtask

   // hold off input and wait until every predicted result has arrived
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.filtered_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input int val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(idx * 4);
      pwdata  <= 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   // random bytes: mostly rows with a legal filter, some bad types and restarts
   task automatic run_random(input int count, input bit fresh_image, input bit restarts);
      logic [7:0] s;
      logic [2:0] ft;
      logic       img;
      int         k, r;
      for (k = 0; k < count; k++) begin
         r  = $urandom_range(0, 99);
         s  = (r < 5) ? 8'h00 : (r < 10) ? 8'hFF : 8'($urandom_range(0, 255));
         ft = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
         if (!restarts) img = 1'b0;
         else if (sb.col == 0) img = ($urandom_range(0, 7) == 0);
         else img = ($urandom_range(0, 49) == 0);
         if (k == 0 && fresh_image) img = 1'b1;
         // never let a row read past what the line store holds
         if (sb.reads_unwritten(img)) img = 1'b1;
         send_byte(s, ft, img);
      end
   endtask

   initial begin
      int p;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-byte rows at reset settings: every filter type, legal and not
      for (p = 0; p < 8; p++) send_byte(p[0] ? 8'h00 : 8'hFF, 3'(p), p == 0);
      drain();

      // four-byte rows of two-byte pixels, paeth first with no row above
      csr_write(REG_ROW_PIXELS, 2);
      csr_write(REG_BYTES_PER_PIXEL, 2);
      for (p = 0; p < 16; p++) send_byte(DIR_BYTES[p], DIR_TYPES[p/4], p == 0);
      // abandon a row after one byte with a new image
      send_byte(8'h5A, FILT_PAETH, 1'b0);
      send_byte(8'hA5, FILT_SUB, 1'b1);
      drain();

      // random phases; settings change while rows are still open
      for (p = 0; p < PHASES; p++) begin
         gaps_on = (p % 3 != 2);
         csr_write(REG_ROW_PIXELS, PHASE_PIX[p]);
         csr_write(REG_BYTES_PER_PIXEL, PHASE_BPP[p]);
         run_random(125, 1'b0, 1'b1);
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.filtered_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #16000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

### png_scanline_filter.f
rtl/pngf_pkg.sv
rtl/pngf_front.sv
rtl/pngf_queue.sv
rtl/pngf_back.sv
rtl/png_scanline_filter.sv
tb/sv/tb_top.sv
